// ----- rtl/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants for the sorted key table and its cell chain.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int CAPACITY = 256;
  localparam int KEY_W    = 32;
  localparam int PAY_W    = 64;
  localparam int POS_W    = 9;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // wide enough for count, position and any cell index plus one
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [PAY_W-1:0] pay_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CMP_W-1:0] cmp_t;
  typedef logic [1:0]       op_t;
  typedef logic [1:0]       status_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_DELETE = 2'd1;
  localparam op_t OP_READ   = 2'd2;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_DUP    = 2'd1;
  localparam status_t ST_FULL   = 2'd2;
  localparam status_t ST_BADPOS = 2'd3;

  typedef struct packed {
    key_t key;
    pay_t payload;
  } rec_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic capture;  // latch compare flags against the new key
    logic ins;      // open a gap and place the new record
    logic del;      // close the gap at the delete position
  } cell_ctrl_t;

endpackage

// ----- rtl/sorted_key_table.sv -----
// ----------------------------------------------------------------------------
// sorted_key_table
// Table of up to CAPACITY records kept in ascending key order in a chain of
// cells; insert at sorted place, delete or read by one-based position.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  in_      input      in_valid/in_stall    opcode, key, payload, position
//  out_     output     out_valid/out_stall  status, found_key, found_payload, entry_count
//
//  the accept edge latches the command and lets each cell compare its key, the
//  next edge applies the shift in all cells at once and loads the result
//  register; no new transaction is accepted until the current one has been
//  applied. synchronous active-low reset empties the table (count zero);
//  cell contents are not cleared. while a result waits under out_stall no new
//  transaction is accepted.
//
module sorted_key_table (
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_opcode,
  input  logic [31:0]            in_key,
  input  logic [63:0]            in_payload,
  input  logic [8:0]             in_position,

  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_status,
  output logic [31:0]            out_found_key,
  output logic [63:0]            out_found_payload,
  output logic [8:0]             out_entry_count
);

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  state_t              state_r;
  skt_pkg::op_t        op_r;
  skt_pkg::rec_t       new_rec_r;
  skt_pkg::pos_t       pos_r;
  skt_pkg::cnt_t       count_r;
  skt_pkg::cnt_t       count_nxt;

  logic                out_valid_r;
  skt_pkg::status_t    out_status_r;
  skt_pkg::status_t    status_nxt;
  skt_pkg::rec_t       out_rec_r;
  skt_pkg::rec_t       found_nxt;
  skt_pkg::pos_t       out_count_r;

  skt_pkg::cell_ctrl_t ctrl;
  logic                any_eq;
  skt_pkg::rec_t       rd_rec;
  logic                in_acc;
  logic                pos_ok;
  logic                ins_ok;
  logic                del_ok;

  // a new transaction only starts when the result slot will be free by apply
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  // position is legal when 1..count
  assign pos_ok = (pos_r != '0) &&
                  (skt_pkg::cmp_t'(pos_r) <= skt_pkg::cmp_t'(count_r));
  // duplicate check wins over the full check
  assign ins_ok = (op_r == skt_pkg::OP_INSERT) && !any_eq &&
                  (skt_pkg::cmp_t'(count_r) != skt_pkg::cmp_t'(skt_pkg::CAPACITY));
  assign del_ok = (op_r == skt_pkg::OP_DELETE) && pos_ok;

  always_comb begin
    ctrl.capture = in_acc;
    ctrl.ins     = (state_r == S_APPLY) && ins_ok;
    ctrl.del     = (state_r == S_APPLY) && del_ok;
  end

  always_comb begin
    count_nxt  = count_r;
    found_nxt  = '0;
    status_nxt = skt_pkg::ST_OK;
    unique case (op_r)
      skt_pkg::OP_INSERT: begin
        if (any_eq) begin
          status_nxt = skt_pkg::ST_DUP;
        end else if (!ins_ok) begin
          status_nxt = skt_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      skt_pkg::OP_DELETE, skt_pkg::OP_READ: begin
        if (!pos_ok) begin
          status_nxt = skt_pkg::ST_BADPOS;
        end else begin
          found_nxt = rd_rec;
          if (del_ok) begin
            count_nxt = count_r - 1'b1;
          end
        end
      end
      default: begin
        // unused opcode: no table change
        status_nxt = skt_pkg::ST_BADPOS;
      end
    endcase
  end

  // state, count and the registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_APPLY;
          end
        end
        S_APPLY: begin
          state_r      <= S_IDLE;
          count_r      <= count_nxt;
          out_valid_r  <= 1'b1;
          out_status_r <= status_nxt;
          out_rec_r    <= found_nxt;
          out_count_r  <= skt_pkg::pos_t'(skt_pkg::cmp_t'(count_nxt));
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // command registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r              <= in_opcode;
      new_rec_r.key     <= in_key;
      new_rec_r.payload <= in_payload;
      pos_r             <= in_position;
    end
  end

  // cells compare against the incoming key at the accept edge
  skt_chain u_chain (
    .clk     (clk),
    .ctrl    (ctrl),
    .cmp_key (in_key),
    .new_rec (new_rec_r),
    .count   (count_r),
    .pos     (pos_r),
    .any_eq  (any_eq),
    .rd_rec  (rd_rec)
  );

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_found_key     = out_rec_r.key;
  assign out_found_payload = out_rec_r.payload;
  assign out_entry_count   = out_count_r;

endmodule

// ----- rtl/skt_cell.sv -----
// ----------------------------------------------------------------------------
// skt_cell
// One table slot: holds a record, compares it with the broadcast key and
// moves records to or from its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module skt_cell (
  input  logic                clk,
  input  skt_pkg::cell_ctrl_t ctrl,
  input  skt_pkg::key_t       cmp_key,
  input  skt_pkg::rec_t       new_rec,
  input  logic                occ,
  input  logic                del_here,
  input  skt_pkg::rec_t       left_rec,
  input  logic                left_lt,
  input  skt_pkg::rec_t       right_rec,
  output skt_pkg::rec_t       rec,
  output logic                lt,
  output logic                eq
);

  skt_pkg::rec_t rec_r;
  logic          lt_r;
  logic          eq_r;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      lt_r <= occ && (rec_r.key < cmp_key);
      eq_r <= occ && (rec_r.key == cmp_key);
    end
    if (ctrl.ins && !lt_r) begin
      // first slot not below the key takes the new record, later ones shift up
      rec_r <= left_lt ? new_rec : left_rec;
    end else if (ctrl.del && del_here) begin
      rec_r <= right_rec;
    end
  end

  assign rec = rec_r;
  assign lt  = lt_r;
  assign eq  = eq_r;

endmodule

// ----- rtl/skt_chain.sv -----
// ----------------------------------------------------------------------------
// skt_chain
// Row of table cells with neighbor links, occupancy and position decode,
// duplicate flag and read-out selection.
// ----------------------------------------------------------------------------
module skt_chain (
  input  logic                clk,
  input  skt_pkg::cell_ctrl_t ctrl,
  input  skt_pkg::key_t       cmp_key,
  input  skt_pkg::rec_t       new_rec,
  input  skt_pkg::cnt_t       count,
  input  skt_pkg::pos_t       pos,
  output logic                any_eq,
  output skt_pkg::rec_t       rd_rec
);

  skt_pkg::rec_t cell_rec [skt_pkg::CAPACITY];
  logic          cell_lt  [skt_pkg::CAPACITY];
  logic          cell_eq  [skt_pkg::CAPACITY];
  logic          cell_sel [skt_pkg::CAPACITY];

  genvar i;
  generate
    for (i = 0; i < skt_pkg::CAPACITY; i++) begin : g_cell
      skt_pkg::rec_t l_rec;
      skt_pkg::rec_t r_rec;
      logic          l_lt;
      logic          occ;
      logic          del_here;

      if (i == 0) begin : g_head
        assign l_rec = '0;
        assign l_lt  = 1'b1;
      end else begin : g_link_l
        assign l_rec = cell_rec[i-1];
        assign l_lt  = cell_lt[i-1];
      end

      if (i == skt_pkg::CAPACITY - 1) begin : g_tail
        assign r_rec = '0;
      end else begin : g_link_r
        assign r_rec = cell_rec[i+1];
      end

      assign occ         = skt_pkg::cmp_t'(count) > skt_pkg::cmp_t'(i);
      assign del_here    = skt_pkg::cmp_t'(pos) <= skt_pkg::cmp_t'(i + 1);
      assign cell_sel[i] = skt_pkg::cmp_t'(pos) == skt_pkg::cmp_t'(i + 1);

      skt_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .cmp_key   (cmp_key),
        .new_rec   (new_rec),
        .occ       (occ),
        .del_here  (del_here),
        .left_rec  (l_rec),
        .left_lt   (l_lt),
        .right_rec (r_rec),
        .rec       (cell_rec[i]),
        .lt        (cell_lt[i]),
        .eq        (cell_eq[i])
      );
    end
  endgenerate

  always_comb begin
    any_eq = 1'b0;
    rd_rec = '0;
    for (int j = 0; j < skt_pkg::CAPACITY; j++) begin
      any_eq = any_eq | cell_eq[j];
      rd_rec = rd_rec | (cell_sel[j] ? cell_rec[j] : '0);
    end
  end

endmodule

// ----- tb/sorted_key_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_tb
// Self-checking bench for the sorted key table. A shadow table in the bench
// predicts status, found record and count for every accepted transaction.
// Directed corner cases come first, then a fill to capacity, then random
// traffic under several idle and stall mixes and a long output hold-off.
// ----------------------------------------------------------------------------
module sorted_key_table_tb;

  // opcode three is unused by the block and must come back as a bad position
  localparam skt_pkg::op_t OP_UNUSED  = 2'd3;
  // run-away limit for the whole bench
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  PRINT_CAP   = 40;

  typedef struct packed {
    skt_pkg::status_t          status;
    skt_pkg::key_t             found_key;
    skt_pkg::pay_t             found_payload;
    logic [skt_pkg::POS_W-1:0] entry_count;
  } table_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = '0;
  logic [31:0] in_key = '0;
  logic [63:0] in_payload = '0;
  logic [8:0]  in_position = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_found_key;
  logic [63:0] out_found_payload;
  logic [8:0]  out_entry_count;

  // shadow copy of the table contents, kept in ascending key order
  skt_pkg::key_t shadow_keys [skt_pkg::CAPACITY];
  skt_pkg::pay_t shadow_pays [skt_pkg::CAPACITY];
  int   shadow_count = 0;

  // replies predicted at acceptance, oldest first
  table_reply_t replies_q[$];

  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic hold_off = 1'b0;

  sorted_key_table dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_key            (in_key),
    .in_payload        (in_payload),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_found_key     (out_found_key),
    .out_found_payload (out_found_payload),
    .out_entry_count   (out_entry_count)
  );

  always #5 clk = ~clk;

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_key_table_tb: done, errors");
      $finish;
    end
  end

  // receiver: random stalls, or a solid hold-off while hold_off is up
  always @(posedge clk) begin
    if (hold_off) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("mismatch at %0t: %s", $time, what);
  endtask

  // apply one command to the shadow table and return the reply it must give
  function automatic table_reply_t apply_to_shadow(skt_pkg::op_t op, skt_pkg::key_t k,
                                                   skt_pkg::pay_t p, skt_pkg::pos_t pos);
    table_reply_t r;
    int slot;
    r = '0;
    r.status = skt_pkg::ST_OK;
    case (op)
      skt_pkg::OP_INSERT: begin
        slot = 0;
        while (slot < shadow_count && shadow_keys[slot] < k) slot++;
        // duplicate check wins over the full check
        if (slot < shadow_count && shadow_keys[slot] == k) begin
          r.status = skt_pkg::ST_DUP;
        end else if (shadow_count >= skt_pkg::CAPACITY) begin
          r.status = skt_pkg::ST_FULL;
        end else begin
          for (int j = shadow_count; j > slot; j--) begin
            shadow_keys[j] = shadow_keys[j-1];
            shadow_pays[j] = shadow_pays[j-1];
          end
          shadow_keys[slot] = k;
          shadow_pays[slot] = p;
          shadow_count++;
        end
      end
      skt_pkg::OP_DELETE, skt_pkg::OP_READ: begin
        if (pos == 0 || int'(pos) > shadow_count) begin
          r.status = skt_pkg::ST_BADPOS;
        end else begin
          r.found_key     = shadow_keys[pos-1];
          r.found_payload = shadow_pays[pos-1];
          if (op == skt_pkg::OP_DELETE) begin
            for (int j = pos - 1; j + 1 < shadow_count; j++) begin
              shadow_keys[j] = shadow_keys[j+1];
              shadow_pays[j] = shadow_pays[j+1];
            end
            shadow_count--;
          end
        end
      end
      default: r.status = skt_pkg::ST_BADPOS;
    endcase
    r.entry_count = skt_pkg::POS_W'(shadow_count);
    return r;
  endfunction

  function automatic bit shadow_holds(skt_pkg::key_t k);
    for (int i = 0; i < shadow_count; i++) if (shadow_keys[i] == k) return 1'b1;
    return 1'b0;
  endfunction

  // offer one transaction, hold it until taken, predict at the accept edge
  task automatic send_cmd(skt_pkg::op_t op, skt_pkg::key_t k, skt_pkg::pay_t p,
                          skt_pkg::pos_t pos);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_key      <= k;
    in_payload  <= p;
    in_position <= pos;
    do @(posedge clk); while (in_stall);
    replies_q.push_back(apply_to_shadow(op, k, p, pos));
  endtask

  // drop valid and wait for every outstanding reply
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (replies_q.size() != 0) @(posedge clk);
  endtask

  // reply checker: compare each accepted reply with the oldest prediction
  always @(posedge clk) begin
    table_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (replies_q.size() == 0) begin
        report_mismatch("reply with no transaction outstanding");
      end else begin
        want = replies_q.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
        if (out_found_key !== want.found_key)
          report_mismatch($sformatf("found_key %h, want %h", out_found_key, want.found_key));
        if (out_found_payload !== want.found_payload)
          report_mismatch($sformatf("found_payload %h, want %h",
                                    out_found_payload, want.found_payload));
        if (out_entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count %0d, want %0d",
                                    out_entry_count, want.entry_count));
      end
    end
  end

  function automatic skt_pkg::pay_t rand_pay();
    return {$urandom, $urandom};
  endfunction

  // keys: stored ones for duplicates, a narrow pool for collisions, extremes, wide
  function automatic skt_pkg::key_t pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 25 && shadow_count > 0) return shadow_keys[$urandom_range(shadow_count - 1)];
    if (r < 60) return skt_pkg::key_t'($urandom_range(255));
    if (r < 63) return '0;
    if (r < 66) return '1;
    return $urandom;
  endfunction

  // positions: mostly legal, plus zero and everything past the count up to 511
  function automatic skt_pkg::pos_t pick_pos();
    int r;
    r = $urandom_range(99);
    if (r < 75 && shadow_count > 0) return skt_pkg::pos_t'($urandom_range(shadow_count, 1));
    if (r < 85) return '0;
    return skt_pkg::pos_t'($urandom_range(511, shadow_count + 1));
  endfunction

  // insert weight steers the count away from the ends of the table
  function automatic skt_pkg::op_t pick_op();
    int r;
    int ins_pct;
    r = $urandom_range(99);
    ins_pct = (shadow_count < 20) ? 55 : (shadow_count > 200) ? 25 : 42;
    if (r < 3) return OP_UNUSED;
    if (r < 3 + ins_pct) return skt_pkg::OP_INSERT;
    if (r < 3 + ins_pct + (97 - ins_pct) / 2) return skt_pkg::OP_DELETE;
    return skt_pkg::OP_READ;
  endfunction

  task automatic send_random();
    send_cmd(pick_op(), pick_key(), rand_pay(), pick_pos());
  endtask

  // corner cases on a small table
  task automatic test_directed();
    send_cmd(skt_pkg::OP_READ,   32'h0, '0, 9'd1);             // read on empty table
    send_cmd(skt_pkg::OP_DELETE, 32'h0, '0, 9'd0);             // delete at position zero
    send_cmd(OP_UNUSED, '1, '1, '1);                           // unused opcode
    send_cmd(skt_pkg::OP_INSERT, 32'h8000_0000, '1, '0);
    send_cmd(skt_pkg::OP_INSERT, 32'h0000_0000, '0, '1);       // lowest key goes first
    send_cmd(skt_pkg::OP_INSERT, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF, '0);
    send_cmd(skt_pkg::OP_INSERT, 32'h8000_0000, rand_pay(), '0); // duplicate in the middle
    send_cmd(skt_pkg::OP_INSERT, 32'hFFFF_FFFF, rand_pay(), '0); // duplicate at the tail
    send_cmd(skt_pkg::OP_INSERT, 32'h0000_0000, rand_pay(), '0); // duplicate at the head
    send_cmd(skt_pkg::OP_READ,   '0, '0, 9'd1);
    send_cmd(skt_pkg::OP_READ,   '0, '0, 9'd2);
    send_cmd(skt_pkg::OP_READ,   '0, '0, 9'd3);
    send_cmd(skt_pkg::OP_READ,   '0, '0, 9'd4);                // one past the count
    send_cmd(skt_pkg::OP_READ,   '0, '0, 9'd0);
    send_cmd(skt_pkg::OP_READ,   '0, '0, 9'd256);
    send_cmd(skt_pkg::OP_DELETE, '1, '1, 9'd511);              // far past the count
    send_cmd(skt_pkg::OP_DELETE, '0, '0, 9'd2);                // middle entry
    send_cmd(skt_pkg::OP_DELETE, '0, '0, 9'd2);                // now the last entry
    send_cmd(skt_pkg::OP_READ,   '0, '0, 9'd1);
    send_cmd(skt_pkg::OP_DELETE, '0, '0, 9'd1);                // back to empty
    send_cmd(skt_pkg::OP_DELETE, '0, '0, 9'd1);
    send_cmd(OP_UNUSED, $urandom, rand_pay(), 9'd1);  // unused opcode, legal-looking pos
    wait_drained();
  endtask

  // fill to capacity, then full and duplicate refusals at the boundary
  task automatic test_fill_to_capacity();
    skt_pkg::key_t k;
    while (shadow_count < skt_pkg::CAPACITY) begin
      do k = $urandom; while (shadow_holds(k));
      send_cmd(skt_pkg::OP_INSERT, k, rand_pay(), skt_pkg::pos_t'($urandom));
    end
    do k = $urandom; while (shadow_holds(k));
    send_cmd(skt_pkg::OP_INSERT, k, rand_pay(), '0);           // full table
    send_cmd(skt_pkg::OP_INSERT, shadow_keys[$urandom_range(skt_pkg::CAPACITY - 1)],
             rand_pay(), '0);
    send_cmd(skt_pkg::OP_READ,   '0, '0, 9'(skt_pkg::CAPACITY));        // last slot
    send_cmd(skt_pkg::OP_READ,   '0, '0, 9'(skt_pkg::CAPACITY + 1));
    send_cmd(skt_pkg::OP_DELETE, '0, '0, 9'(skt_pkg::CAPACITY));
    send_cmd(skt_pkg::OP_INSERT, k, rand_pay(), '0);           // room again
    send_cmd(skt_pkg::OP_INSERT, ~k, rand_pay(), '0);
    send_cmd(skt_pkg::OP_DELETE, '0, '0, 9'd1);
    send_cmd(skt_pkg::OP_READ,   '0, '0, 9'd1);
    wait_drained();
  endtask

  // random mix under one idle/stall setting
  task automatic test_random_traffic(int n_items, int idle_pct, int stall_in_pct);
    send_idle_pct <= idle_pct;
    stall_pct     <= stall_in_pct;
    @(posedge clk);
    repeat (n_items) send_random();
    wait_drained();
  endtask

  // long output hold-off with the sender still offering, so the input stalls
  task automatic test_output_holdoff();
    send_idle_pct <= 0;
    stall_pct     <= 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
      begin
        repeat (30) send_random();
      end
    join
    wait_drained();
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_to_capacity();
    test_random_traffic(140, 0, 0);
    test_random_traffic(130, 71, 0);
    test_random_traffic(130, 0, 71);
    test_random_traffic(130, 23, 23);
    test_output_holdoff();
    test_random_traffic(60, 0, 0);

    // settle: let any outstanding replies drain
    stall_pct <= 0;
    repeat (10) @(posedge clk);
    if (replies_q.size() != 0)
      report_mismatch($sformatf("%0d replies never arrived", replies_q.size()));
    if (mismatch_count == 0) begin
      $display("sorted_key_table_tb: done, clean");
    end else begin
      $display("sorted_key_table_tb: done, errors");
    end
    $finish;
  end

endmodule
